@@ design/binary_max_heap_priority_queue_macros.svh @@
// Assertion macros for the heap priority queue.
`ifndef BINARY_MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
`define BMHPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmhpq: implication check failed");
`define BMHPQ_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("bmhpq: forbidden condition seen");
`else
`define BMHPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define BMHPQ_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ design/bmhpq_pkg.sv @@
// Shared constants, types and helper functions for the heap priority queue.
`timescale 1ns / 1ps
package bmhpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int NLVL     = CNT_W;
    localparam int LVL_W    = $clog2(NLVL);

    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_EXTRACTED = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef enum logic [1:0] {
        OP_INS,
        OP_PASS,
        OP_DOWN
    } t_op;

    // word travelling down the chain
    typedef struct packed {
        logic                    valid;
        t_op                     op;
        logic [LVL_W-1:0]        tlvl;
        logic [IDX_W-1:0]        idx;
        logic [CNT_W-1:0]        path;
        logic [CNT_W-1:0]        cnt;
        logic signed [KEY_W-1:0] key;
    } t_tok;

    // write-back to the level above
    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        idx;
        logic signed [KEY_W-1:0] key;
    } t_wr;

    typedef struct packed {
        logic                    valid;
        logic [LVL_W-1:0]        lvl;
        logic [IDX_W-1:0]        idx;
    } t_peek;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
    } t_done;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [KEY_W-1:0] wdata;
        logic [IDX_W-1:0] raddr_a;
        logic [IDX_W-1:0] raddr_b;
    } t_ram_req;

    function automatic int lvl_depth(input int lvl);
        int p;
        int rem;
        p   = 1 << lvl;
        rem = CAPACITY + 1 - p;
        return (p < rem) ? p : rem;
    endfunction

    function automatic int lvl_aw(input int lvl);
        int aw;
        aw = $clog2(lvl_depth(lvl));
        return (aw < 1) ? 1 : aw;
    endfunction

    function automatic logic [LVL_W-1:0] msb_pos(input logic [CNT_W-1:0] v);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (v[i]) begin
                r = LVL_W'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ design/bmhpq_ram.sv @@
// Simple dual-read, single-write RAM with registered read data.
`timescale 1ns / 1ps
module bmhpq_ram #(
    parameter int AW = 1,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

@@ design/bmhpq_cell.sv @@
// One heap level: compares against its stored nodes and hands words to the next level.
`timescale 1ns / 1ps
module bmhpq_cell
    import bmhpq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [LVL_W-1:0] i_level,
    input  t_tok             i_tok,
    input  t_wr              i_wr,
    input  t_peek            i_peek,
    input  logic [KEY_W-1:0] i_rdata_a,
    input  logic [KEY_W-1:0] i_rdata_b,
    output t_tok             o_tok,
    output t_wr              o_wr,
    output t_done            o_done,
    output t_ram_req         o_ram
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_INS_CMP,
        C_DN_CMP
    } t_cstate;

    t_cstate r_state;
    t_tok    r_cur;
    t_tok    r_tok;
    t_wr     r_wr;
    logic    r_done;
    logic    r_peek_q;

    t_tok                    w_src;
    logic                    w_at_tgt;
    logic [LVL_W-1:0]        w_sh;
    logic                    w_pbit;
    logic [IDX_W:0]          w_nidx;
    logic [IDX_W:0]          w_ka;
    logic [IDX_W:0]          w_kb;
    logic [CNT_W:0]          w_base;
    logic [CNT_W:0]          w_ha;
    logic                    w_va;
    logic                    w_vb;
    logic                    w_peek_hit;
    logic signed [KEY_W-1:0] w_node_a;
    logic signed [KEY_W-1:0] w_node_b;
    logic                    w_gt;
    logic signed [KEY_W-1:0] w_fwd_key;
    logic                    w_take_a;
    logic                    w_take_b;
    logic signed [KEY_W-1:0] w_best_a;
    logic signed [KEY_W-1:0] w_best;
    logic [IDX_W-1:0]        w_child;

    always_comb begin
        w_src      = (r_state == C_IDLE) ? i_tok : r_cur;
        w_at_tgt   = (i_level == w_src.tlvl);
        w_sh       = w_src.tlvl - i_level - LVL_W'(1);
        w_pbit     = w_src.path[w_sh];
        w_nidx     = {w_src.idx, w_pbit};
        w_ka       = {w_src.idx, 1'b0};
        w_kb       = {w_src.idx, 1'b1};
        w_base     = ((CNT_W+1)'(1) << i_level) - (CNT_W+1)'(1);
        w_ha       = w_base + (CNT_W+1)'(w_ka);
        w_va       = w_ha < {1'b0, w_src.cnt};
        w_vb       = (w_ha + (CNT_W+1)'(1)) < {1'b0, w_src.cnt};
        w_peek_hit = i_peek.valid && (i_peek.lvl == i_level);
        w_node_a   = $signed(i_rdata_a);
        w_node_b   = $signed(i_rdata_b);
        w_gt       = w_src.key > w_node_a;
        w_fwd_key  = w_gt ? w_node_a : w_src.key;
        // ties keep the parent, equal children favour the left
        w_take_a   = w_va && (w_node_a > w_src.key);
        w_best_a   = w_take_a ? w_node_a : w_src.key;
        w_take_b   = w_vb && (w_node_b > w_best_a);
        w_best     = w_take_b ? w_node_b : w_best_a;
        w_child    = w_take_b ? w_kb[IDX_W-1:0] : w_ka[IDX_W-1:0];
    end

    always_comb begin
        o_ram = '0;
        if (w_peek_hit) begin
            o_ram.raddr_a = i_peek.idx;
        end
        unique case (r_state)
            C_IDLE: begin
                if (i_tok.valid) begin
                    case (i_tok.op)
                        OP_INS: begin
                            if (w_at_tgt) begin
                                o_ram.we    = 1'b1;
                                o_ram.waddr = i_tok.idx;
                                o_ram.wdata = i_tok.key;
                            end else begin
                                o_ram.raddr_a = i_tok.idx;
                            end
                        end
                        OP_DOWN: begin
                            o_ram.raddr_a = w_ka[IDX_W-1:0];
                            o_ram.raddr_b = w_kb[IDX_W-1:0];
                        end
                        default: ;
                    endcase
                end
            end
            C_INS_CMP: begin
                if (w_gt) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_cur.idx;
                    o_ram.wdata = r_cur.key;
                end
            end
            C_DN_CMP: ;
            default: ;
        endcase
        if (i_wr.valid) begin
            o_ram.we    = 1'b1;
            o_ram.waddr = i_wr.idx;
            o_ram.wdata = i_wr.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= C_IDLE;
            r_tok.valid <= 1'b0;
            r_wr.valid  <= 1'b0;
            r_done      <= 1'b0;
            r_peek_q    <= 1'b0;
        end else begin
            r_tok.valid <= 1'b0;
            r_wr.valid  <= 1'b0;
            r_done      <= 1'b0;
            r_peek_q    <= w_peek_hit;
            unique case (r_state)
                C_IDLE: begin
                    if (i_tok.valid) begin
                        case (i_tok.op)
                            OP_INS: begin
                                if (w_at_tgt) begin
                                    r_done <= 1'b1;
                                end else begin
                                    r_cur   <= i_tok;
                                    r_state <= C_INS_CMP;
                                end
                            end
                            OP_PASS: begin
                                r_tok    <= i_tok;
                                r_tok.op <= OP_DOWN;
                            end
                            OP_DOWN: begin
                                if (!w_va) begin
                                    r_wr.valid <= 1'b1;
                                    r_wr.idx   <= i_tok.idx;
                                    r_wr.key   <= i_tok.key;
                                    r_done     <= 1'b1;
                                end else begin
                                    r_cur   <= i_tok;
                                    r_state <= C_DN_CMP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                C_INS_CMP: begin
                    r_tok     <= r_cur;
                    r_tok.idx <= w_nidx[IDX_W-1:0];
                    r_tok.key <= w_fwd_key;
                    r_state   <= C_IDLE;
                end
                C_DN_CMP: begin
                    r_wr.valid <= 1'b1;
                    r_wr.idx   <= r_cur.idx;
                    r_wr.key   <= w_best;
                    if (w_take_a || w_take_b) begin
                        r_tok     <= r_cur;
                        r_tok.idx <= w_child;
                    end else begin
                        r_done <= 1'b1;
                    end
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_tok       = r_tok;
    assign o_wr        = r_wr;
    assign o_done.valid = r_done | r_peek_q;
    assign o_done.key   = r_peek_q ? w_node_a : '0;

endmodule

@@ design/binary_max_heap_priority_queue.sv @@
// Top level: max priority queue of signed keys, one heap level per cell.
//
// Input channel: i_in_valid / o_in_stall with i_kind (0 insert, 1 extract max)
// and i_key_in. A word is taken when i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid / i_out_stall with o_key_out, o_status and
// o_count_after; exactly one result word per input word, in order.
// One operation is in flight at a time. An insert walks from the root down the
// path to the new slot, level by level (RAM read, then compare/write). An
// extract reads the root and the last entry, then sifts the moved key down,
// again with a RAM read, then a compare/write, at each level. Extracting the
// only key skips the sift; rejected inserts and empty extracts go straight to
// the result. The queue returns to idle as the result is registered, and the
// next word can be taken from then on.
// The output register lets a new word be taken while a result waits; if
// i_out_stall holds, the next finished result waits inside until it clears.
// Reset empties the queue; RAM contents are not cleared and need no sweep.
`timescale 1ns / 1ps
`include "binary_max_heap_priority_queue_macros.svh"
module binary_max_heap_priority_queue
    import bmhpq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_kind,
    input  logic signed [KEY_W-1:0] i_key_in,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [KEY_W-1:0] o_key_out,
    output logic [1:0]              o_status,
    output logic [CNT_W-1:0]        o_count_after
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PK_ROOT,
        S_PK_LAST,
        S_PK_WAIT,
        S_DOWN,
        S_RESULT
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_count;
    t_tok                    r_tok;
    logic signed [KEY_W-1:0] r_res_key;
    logic [1:0]              r_res_status;
    logic [CNT_W-1:0]        r_res_cnt;
    logic                    r_out_valid;
    logic signed [KEY_W-1:0] r_key_out;
    logic [1:0]              r_status;
    logic [CNT_W-1:0]        r_count_out;

    t_tok             w_tok  [NLVL+1];
    t_wr              w_wr   [NLVL+1];
    t_done            w_done [NLVL];
    t_ram_req         w_ram  [NLVL];
    logic [KEY_W-1:0] w_rd_a [NLVL];
    logic [KEY_W-1:0] w_rd_b [NLVL];
    logic [NLVL-1:0]  w_done_v;
    t_peek            w_peek;

    logic                    w_any_done;
    logic signed [KEY_W-1:0] w_done_key;
    logic                    w_accept;
    logic [CNT_W-1:0]        w_cnt_inc;
    logic [CNT_W-1:0]        w_cnt_dec;
    logic [LVL_W-1:0]        w_last_lvl;
    logic [CNT_W-1:0]        w_last_loc;
    logic                    w_out_free;

    assign w_tok[0]    = r_tok;
    assign w_wr[NLVL]  = '0;

    genvar g;
    generate
        for (g = 0; g < NLVL; g++) begin : g_lvl
            localparam int AW = lvl_aw(g);

            bmhpq_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_level   (LVL_W'(g)),
                .i_tok     (w_tok[g]),
                .i_wr      (w_wr[g+1]),
                .i_peek    (w_peek),
                .i_rdata_a (w_rd_a[g]),
                .i_rdata_b (w_rd_b[g]),
                .o_tok     (w_tok[g+1]),
                .o_wr      (w_wr[g]),
                .o_done    (w_done[g]),
                .o_ram     (w_ram[g])
            );

            bmhpq_ram #(
                .AW (AW),
                .DW (KEY_W)
            ) u_ram (
                .i_clk     (i_clk),
                .i_we      (w_ram[g].we),
                .i_waddr   (w_ram[g].waddr[AW-1:0]),
                .i_wdata   (w_ram[g].wdata),
                .i_raddr_a (w_ram[g].raddr_a[AW-1:0]),
                .i_raddr_b (w_ram[g].raddr_b[AW-1:0]),
                .o_rdata_a (w_rd_a[g]),
                .o_rdata_b (w_rd_b[g])
            );

            assign w_done_v[g] = w_done[g].valid;
        end
    endgenerate

    always_comb begin
        w_done_key = '0;
        for (int i = 0; i < NLVL; i++) begin
            if (w_done[i].valid) begin
                w_done_key = w_done_key | w_done[i].key;
            end
        end
    end

    assign w_any_done = |w_done_v;
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_cnt_inc  = r_count + CNT_W'(1);
    assign w_cnt_dec  = r_count - CNT_W'(1);
    assign w_last_lvl = msb_pos(r_count);
    assign w_last_loc = r_count ^ (CNT_W'(1) << w_last_lvl);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_peek = '0;
        if (r_state == S_PK_ROOT) begin
            w_peek.valid = 1'b1;
        end else if (r_state == S_PK_LAST) begin
            w_peek.valid = 1'b1;
            w_peek.lvl   = w_last_lvl;
            w_peek.idx   = IDX_W'(w_last_loc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_tok.valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tok.valid <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_key <= '0;
                        if (i_kind == KIND_INSERT) begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                r_res_status <= ST_FULL;
                                r_res_cnt    <= r_count;
                                r_state      <= S_RESULT;
                            end else begin
                                r_tok.valid  <= 1'b1;
                                r_tok.op     <= OP_INS;
                                r_tok.tlvl   <= msb_pos(w_cnt_inc);
                                r_tok.idx    <= '0;
                                r_tok.path   <= w_cnt_inc;
                                r_tok.cnt    <= w_cnt_inc;
                                r_tok.key    <= i_key_in;
                                r_res_status <= ST_INSERTED;
                                r_res_cnt    <= w_cnt_inc;
                                r_state      <= S_INS;
                            end
                        end else begin
                            if (r_count == '0) begin
                                r_res_status <= ST_EMPTY;
                                r_res_cnt    <= r_count;
                                r_state      <= S_RESULT;
                            end else begin
                                r_res_status <= ST_EXTRACTED;
                                r_res_cnt    <= w_cnt_dec;
                                r_state      <= S_PK_ROOT;
                            end
                        end
                    end
                end
                S_INS: begin
                    if (w_any_done) begin
                        r_count <= w_cnt_inc;
                        r_state <= S_RESULT;
                    end
                end
                S_PK_ROOT: r_state <= S_PK_LAST;
                S_PK_LAST: begin
                    r_res_key <= w_done_key;
                    r_state   <= S_PK_WAIT;
                end
                S_PK_WAIT: begin
                    r_count <= w_cnt_dec;
                    if (w_cnt_dec == '0) begin
                        r_state <= S_RESULT;
                    end else begin
                        r_tok.valid <= 1'b1;
                        r_tok.op    <= OP_PASS;
                        r_tok.tlvl  <= '0;
                        r_tok.idx   <= '0;
                        r_tok.path  <= '0;
                        r_tok.cnt   <= w_cnt_dec;
                        r_tok.key   <= w_done_key;
                        r_state     <= S_DOWN;
                    end
                end
                S_DOWN: begin
                    if (w_any_done) begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_key_out   <= r_res_key;
                        r_status    <= r_res_status;
                        r_count_out <= r_res_cnt;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_key_out     = r_key_out;
    assign o_status      = r_status;
    assign o_count_after = r_count_out;

    `BMHPQ_ASSERT_NEVER(a_no_tok_past_last, i_clk, i_rst_n, w_tok[NLVL].valid)
    `BMHPQ_ASSERT_NEVER(a_no_root_writeup, i_clk, i_rst_n, w_wr[0].valid)
    `BMHPQ_ASSERT_NEVER(a_single_done, i_clk, i_rst_n, !$onehot0(w_done_v))
    `BMHPQ_ASSERT_NEVER(a_count_in_range, i_clk, i_rst_n, r_count > CNT_W'(CAPACITY))
    `BMHPQ_ASSERT_IMPLY(a_done_only_busy, i_clk, i_rst_n, w_any_done, (r_state != S_IDLE && r_state != S_RESULT))

endmodule
